[hdl/bdd_pkg.sv]
// ----------------------------------------------------------------------------
// bdd_pkg: shared definitions for the binary disk dilation unit
// Sizes, register indexes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bdd_pkg;

   localparam int MAX_HEIGHT = 256;
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_RADIUS = 7;

   // Fixed field widths of the item and register formats.
   localparam int ROW_W     = 8;
   localparam int COL_W     = 8;
   localparam int RADIUS_W  = 3;
   localparam int CFG_DIM_W = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 9;
   localparam int REQ_DAT_W = 24;
   localparam int RSP_DAT_W = 24;

   // Derived sizes.
   localparam int MAX_DIM  = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
   localparam int DIM_W    = $clog2(MAX_DIM + 1);
   localparam int RAD_W    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
   localparam int OFS_W    = RAD_W + 1;
   localparam int SQ_W     = 2 * OFS_W + 1;
   localparam int COORD_W  = ((DIM_W > ROW_W + 1) ? DIM_W : ROW_W + 1) + 1;
   localparam int DEPTH    = MAX_HEIGHT * MAX_WIDTH;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd2;

   // Item kinds carried on req_tuser.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [RADIUS_W-1:0]  RADIUS_RST = 3'd2;
   localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 9'd256;
   localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 9'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } bdd_state_type;

   typedef struct packed {
      logic wr_pixel;
      logic load_query;
      logic step;
      logic out_load;
   } bdd_cmd_type;

   typedef struct packed {
      logic in_frame;
      logic last_offset;
      logic out_free;
   } bdd_stat_type;

   // Frame dimension forced into 1..maxv; zero acts as one.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DIM_W-1:0] v,
                                                  input int unsigned maxv);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if (32'(v) > maxv) begin
         res = DIM_W'(maxv);
      end else begin
         res = DIM_W'(v);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[hdl/binary_disk_dilation_unit.sv]
// ----------------------------------------------------------------------------
// binary_disk_dilation_unit: binary dilation with a disk element
// Stores a thresholded bit mask and answers dilated-pixel queries.
// ----------------------------------------------------------------------------
// A word with req_tuser low writes one mask bit into the frame store. A word
// with req_tuser high queries the dilated value at (row, col): the controller
// walks every offset of the square of side 2*radius+1 around the point, one
// per cycle, reading the single read port of the frame store for offsets
// inside the disk and the frame. A query outside the frame returns zero. The
// result sits in an output register, so the next word is accepted while it
// waits to be taken. Configuration writes are always ready; change them only
// while no query is in flight.
`default_nettype none

module binary_disk_dilation_unit import bdd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // Request stream.
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [REQ_DAT_W-1:0] req_tdata,  // row[7:0], col[15:8], pixel[16], zero pad
   input  wire logic                 req_tuser,  // op: 0 write, 1 query
   // Response stream.
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_DAT_W-1:0]      rsp_tdata,  // out_row[7:0], out_col[15:8], dilated[16], zero pad
   // Configuration writes.
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   bdd_cmd_type       cmd;
   bdd_stat_type      stat;
   logic [ROW_W-1:0]  rsp_row;
   logic [COL_W-1:0]  rsp_col;
   logic              rsp_dilated;

   bdd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bdd_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_row     (req_tdata[ROW_W-1:0]),
      .req_col     (req_tdata[ROW_W+COL_W-1:ROW_W]),
      .req_pixel   (req_tdata[ROW_W+COL_W]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_row     (rsp_row),
      .rsp_col     (rsp_col),
      .rsp_dilated (rsp_dilated),
      .cmd         (cmd),
      .stat        (stat)
   );

   assign rsp_tdata = {{(RSP_DAT_W-ROW_W-COL_W-1){1'b0}}, rsp_dilated, rsp_col, rsp_row};

endmodule

`default_nettype wire

[hdl/bdd_ram.sv]
// ----------------------------------------------------------------------------
// bdd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

[hdl/bdd_ctrl.sv]
// ----------------------------------------------------------------------------
// bdd_ctrl: controller of the binary disk dilation unit
// Sequences one query through the offset scan, drain and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_ctrl import bdd_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_op,
   output logic              req_tready,
   input  wire bdd_stat_type stat,
   output bdd_cmd_type       cmd
);

   bdd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_op == OP_QUERY) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stat.in_frame) begin
               state_in = ST_FINISH;
            end else if (stat.last_offset) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = 1'b0;
      cmd            = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.wr_pixel   = req_tvalid && req_op == OP_WRITE;
            cmd.load_query = req_tvalid && req_op == OP_QUERY;
         end
         ST_SCAN: begin
            cmd.step = stat.in_frame;
         end
         ST_DRAIN: begin
         end
         ST_FINISH: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/bdd_dp.sv]
// ----------------------------------------------------------------------------
// bdd_dp: datapath of the binary disk dilation unit
// Configuration registers, offset counters, frame store access and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bdd_dp import bdd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data,
   input  wire logic [ROW_W-1:0]     req_row,
   input  wire logic [COL_W-1:0]     req_col,
   input  wire logic                 req_pixel,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [ROW_W-1:0]          rsp_row,
   output logic [COL_W-1:0]          rsp_col,
   output logic                      rsp_dilated,
   input  wire bdd_cmd_type          cmd,
   output bdd_stat_type              stat
);

   logic [RADIUS_W-1:0]     radius_ff;
   logic [CFG_DIM_W-1:0]    height_ff;
   logic [CFG_DIM_W-1:0]    width_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [COL_W-1:0]        col_ff;
   logic signed [OFS_W-1:0] dy_ff, dy_in;
   logic signed [OFS_W-1:0] dx_ff, dx_in;
   logic                    pend_ff;
   logic                    hit_ff, hit_in;
   logic                    rsp_valid_ff;
   logic [ROW_W-1:0]        rsp_row_ff;
   logic [COL_W-1:0]        rsp_col_ff;
   logic                    rsp_dil_ff;

   logic [DIM_W-1:0]         h_dim, w_dim;
   logic signed [OFS_W-1:0]  rad;
   logic signed [SQ_W-1:0]   r2, d2;
   logic signed [COORD_W-1:0] nr, nc, h_s, w_s;
   logic                     in_disk, in_bounds, rd_en, wr_en, rd_data;
   logic [ADDR_W-1:0]        rd_addr, wr_addr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RST;
         height_ff <= HEIGHT_RST;
         width_ff  <= WIDTH_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIUS:       radius_ff <= csr_data[RADIUS_W-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_data;
            CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      h_dim = clamp_dim(height_ff, MAX_HEIGHT);
      w_dim = clamp_dim(width_ff, MAX_WIDTH);
      if (32'(radius_ff) > MAX_RADIUS) begin
         rad = OFS_W'(MAX_RADIUS);
      end else begin
         rad = OFS_W'(radius_ff);
      end
      r2  = SQ_W'(rad) * SQ_W'(rad);
      d2  = SQ_W'(dy_ff) * SQ_W'(dy_ff) + SQ_W'(dx_ff) * SQ_W'(dx_ff);
      in_disk = d2 <= r2;

      nr  = COORD_W'($signed({1'b0, row_ff})) + COORD_W'(dy_ff);
      nc  = COORD_W'($signed({1'b0, col_ff})) + COORD_W'(dx_ff);
      h_s = COORD_W'($signed({1'b0, h_dim}));
      w_s = COORD_W'($signed({1'b0, w_dim}));
      in_bounds = nr >= 0 && nr < h_s && nc >= 0 && nc < w_s;

      rd_en   = cmd.step && in_disk && in_bounds;
      rd_addr = ADDR_W'(nr) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nc);
      wr_en   = cmd.wr_pixel && 32'(req_row) < MAX_HEIGHT && 32'(req_col) < MAX_WIDTH;
      wr_addr = ADDR_W'(req_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(req_col);

      stat.in_frame    = COORD_W'(row_ff) < h_s && COORD_W'(col_ff) < w_s;
      stat.last_offset = dy_ff == rad && dx_ff == rad;
      stat.out_free    = !rsp_valid_ff || rsp_tready;
   end

   // Offsets walk row by row over the square around the query point.
   always_comb begin
      dy_in  = dy_ff;
      dx_in  = dx_ff;
      hit_in = hit_ff | (pend_ff & rd_data);
      if (cmd.load_query) begin
         dy_in  = -rad;
         dx_in  = -rad;
         hit_in = 1'b0;
      end else if (cmd.step) begin
         if (dx_ff == rad) begin
            dx_in = -rad;
            dy_in = dy_ff + OFS_W'(1);
         end else begin
            dx_in = dx_ff + OFS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query) begin
         row_ff <= req_row;
         col_ff <= req_col;
      end
      dy_ff  <= dy_in;
      dx_ff  <= dx_in;
      hit_ff <= hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_row_ff <= row_ff;
         rsp_col_ff <= col_ff;
         rsp_dil_ff <= hit_ff;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_row     = rsp_row_ff;
   assign rsp_col     = rsp_col_ff;
   assign rsp_dilated = rsp_dil_ff;

   bdd_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

`ifndef ASSERT_OFF
   a_pend_after_step: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(cmd.step))
      else $error("read data expected without a scan step");

   a_outside_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && !stat.in_frame) |-> !hit_ff)
      else $error("query outside the frame produced a set result");

   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (dy_ff >= -rad && dy_ff <= rad && dx_ff >= -rad && dx_ff <= rad))
      else $error("scan offset left the disk square");
`endif

endmodule

`default_nettype wire
